// ===== rtl/core/iat_pkg.sv =====
`timescale 1ns / 1ps

package iat_pkg;

    localparam longint unsigned SOURCE_BYTES = 64'd65536;
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0]  TAB_WIDTH_RESET = 4'd4;
    localparam logic [11:0] INDENT_MAX      = 12'hFFF;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    typedef enum logic [2:0] {
        MODE_BLANK,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_OP
    } t_mode;

    typedef enum logic [4:0] {
        KIND_INDENT   = 5'd0,
        KIND_INT      = 5'd1,
        KIND_FLOAT    = 5'd2,
        KIND_IDENT    = 5'd3,
        KIND_STRING   = 5'd4,
        KIND_PLUS     = 5'd5,
        KIND_PLUS_EQ  = 5'd6,
        KIND_MINUS    = 5'd7,
        KIND_MINUS_EQ = 5'd8,
        KIND_STAR     = 5'd9,
        KIND_SLASH    = 5'd10,
        KIND_COLON    = 5'd11,
        KIND_COLON_EQ = 5'd12,
        KIND_SCOPE    = 5'd13,
        KIND_ASSIGN   = 5'd14,
        KIND_EQ       = 5'd15,
        KIND_LT       = 5'd16,
        KIND_LE       = 5'd17,
        KIND_GT       = 5'd18,
        KIND_GE       = 5'd19,
        KIND_BANG     = 5'd20,
        KIND_NE       = 5'd21,
        KIND_LPAREN   = 5'd22,
        KIND_RPAREN   = 5'd23,
        KIND_LBRACK   = 5'd24,
        KIND_RBRACK   = 5'd25,
        KIND_COMMA    = 5'd26,
        KIND_EOF      = 5'd27,
        KIND_UNKNOWN  = 5'd28,
        KIND_UNCLOSED = 5'd29
    } t_kind;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic [11:0] indent_amount;
        logic        last_of_run;
    } t_token;

    // all tokens caused by one byte
    typedef struct packed {
        logic [COUNT_W-1:0]            count;
        t_token [MAX_RESULTS-1:0]      recs;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_qport;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_line_break(logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    // characters that open a one-or-two character operator
    function automatic logic is_op_start(logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_COLON) || (c == CH_EQUAL)
            || (c == CH_LT) || (c == CH_GT) || (c == CH_BANG);
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_LPAREN) || (c == CH_RPAREN)
            || (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_COMMA);
    endfunction

    function automatic t_kind punct_kind(logic [7:0] c);
        t_kind k;
        case (c)
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            default:   k = KIND_COMMA;
        endcase
        return k;
    endfunction

    function automatic t_kind single_op_kind(logic [7:0] c);
        t_kind k;
        case (c)
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_COLON: k = KIND_COLON;
            CH_EQUAL: k = KIND_ASSIGN;
            CH_LT:    k = KIND_LT;
            CH_GT:    k = KIND_GT;
            default:  k = KIND_BANG;
        endcase
        return k;
    endfunction

    function automatic logic pair_op_valid(logic [7:0] first, logic [7:0] c);
        return ((first == CH_COLON) && (c == CH_COLON)) || (c == CH_EQUAL);
    endfunction

    function automatic t_kind pair_op_kind(logic [7:0] first, logic [7:0] c);
        t_kind k;
        if ((first == CH_COLON) && (c == CH_COLON)) begin
            k = KIND_SCOPE;
        end else begin
            case (first)
                CH_PLUS:  k = KIND_PLUS_EQ;
                CH_MINUS: k = KIND_MINUS_EQ;
                CH_COLON: k = KIND_COLON_EQ;
                CH_EQUAL: k = KIND_EQ;
                CH_LT:    k = KIND_LE;
                CH_GT:    k = KIND_GE;
                default:  k = KIND_NE;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/iat_if.sv =====
`timescale 1ns / 1ps

interface iat_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       is_last;

    modport source (output valid, output src_byte, output is_last, input ready);
    modport sink   (input valid, input src_byte, input is_last, output ready);
endinterface

interface iat_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [11:0] indent_amount;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output line_number, output column_number,
                    output indent_amount, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input line_number, input column_number,
                    input indent_amount, input last_of_run, output ready);
    modport monitor (input valid, input token_kind, input start_offset,
                     input token_length, input line_number, input column_number,
                     input indent_amount, input last_of_run, input ready);
endinterface

// ===== rtl/core/iat_front.sv =====
`timescale 1ns / 1ps

module iat_front #(
    parameter longint unsigned SOURCE_BYTES = iat_pkg::SOURCE_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [3:0]           i_cfg_wr_data,
    iat_byte_if.sink             i_byte,
    input  logic                 i_q_full,
    output iat_pkg::t_qport      o_q_wr
);

    localparam logic [15:0] OFFSET_CAP =
        ((SOURCE_BYTES - 64'd1) > 64'd65535) ? 16'hFFFF : 16'(SOURCE_BYTES - 64'd1);

    logic [3:0]     r_tab_width;
    iat_pkg::t_mode r_mode,   n_mode;
    logic [7:0]     r_held,   n_held;
    logic [7:0]     r_quote,  n_quote;
    logic           r_dot,    n_dot;
    logic [15:0]    r_off,    n_off;
    logic [15:0]    r_ts,     n_ts;
    logic [15:0]    r_line,   n_line;
    logic [15:0]    r_col,    n_col;
    logic [11:0]    r_indent, n_indent;
    logic           r_als,    n_als;

    iat_pkg::t_bundle bundle;
    logic             accept;

    function automatic iat_pkg::t_token mk_rec(iat_pkg::t_kind kind, logic [15:0] start,
                                               logic [15:0] len, logic [15:0] line,
                                               logic [15:0] col, logic [11:0] ind);
        iat_pkg::t_token r;
        r.token_kind    = kind;
        r.start_offset  = start;
        r.token_length  = len;
        r.line_number   = line;
        r.column_number = col;
        r.indent_amount = ind;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] bump_off(logic [15:0] v);
        return (v < OFFSET_CAP) ? v + 16'd1 : v;
    endfunction

    function automatic logic [15:0] bump_sat(logic [15:0] v);
        return (v < iat_pkg::COUNT_MAX) ? v + 16'd1 : v;
    endfunction

    function automatic logic [11:0] add_indent(logic [11:0] a, logic [3:0] b);
        logic [12:0] sum;
        sum = {1'b0, a} + {9'd0, b};
        return sum[12] ? iat_pkg::INDENT_MAX : sum[11:0];
    endfunction

    assign accept         = i_byte.valid && i_byte.ready;
    assign i_byte.ready   = !i_q_full;
    assign o_q_wr.valid   = accept && (bundle.count != '0);
    assign o_q_wr.bundle  = bundle;

    always_comb begin
        logic [7:0]                   c;
        logic                         to_blank;
        logic                         finish;
        logic [iat_pkg::COUNT_W-1:0]  cnt;
        iat_pkg::t_token [iat_pkg::MAX_RESULTS-1:0] recs;

        c        = i_byte.src_byte;
        n_mode   = r_mode;
        n_held   = r_held;
        n_quote  = r_quote;
        n_dot    = r_dot;
        n_off    = r_off;
        n_ts     = r_ts;
        n_line   = r_line;
        n_col    = r_col;
        n_indent = r_indent;
        n_als    = r_als;
        recs     = '0;
        cnt      = '0;
        to_blank = 1'b0;
        finish   = 1'b0;

        if (c == iat_pkg::CH_NUL) begin
            finish = 1'b1;
        end else begin
            case (n_mode)
                iat_pkg::MODE_IDENT: begin
                    if (iat_pkg::is_alpha(c) || iat_pkg::is_digit(c)) begin
                        n_off = bump_off(n_off);
                        n_col = bump_sat(n_col);
                    end else begin
                        recs[cnt] = mk_rec(iat_pkg::KIND_IDENT, n_ts, n_off - n_ts,
                                           n_line, n_col, 12'd0);
                        cnt = cnt + 1'b1;
                        to_blank = 1'b1;
                    end
                end
                iat_pkg::MODE_NUMBER: begin
                    if (iat_pkg::is_digit(c) || (c == iat_pkg::CH_DOT)) begin
                        if (c == iat_pkg::CH_DOT) begin
                            n_dot = 1'b1;
                        end
                        n_off = bump_off(n_off);
                        n_col = bump_sat(n_col);
                    end else begin
                        recs[cnt] = mk_rec(n_dot ? iat_pkg::KIND_FLOAT : iat_pkg::KIND_INT,
                                           n_ts, n_off - n_ts, n_line, n_col, 12'd0);
                        cnt = cnt + 1'b1;
                        to_blank = 1'b1;
                    end
                end
                iat_pkg::MODE_OP: begin
                    if (iat_pkg::pair_op_valid(n_held, c)) begin
                        n_off = bump_off(n_off);
                        n_col = bump_sat(n_col);
                        recs[cnt] = mk_rec(iat_pkg::pair_op_kind(n_held, c), n_ts,
                                           n_off - n_ts, n_line, n_col, 12'd0);
                        cnt = cnt + 1'b1;
                        n_mode = iat_pkg::MODE_BLANK;
                        n_held = '0;
                    end else begin
                        recs[cnt] = mk_rec(iat_pkg::single_op_kind(n_held), n_ts,
                                           n_off - n_ts, n_line, n_col, 12'd0);
                        cnt = cnt + 1'b1;
                        n_held = '0;
                        to_blank = 1'b1;
                    end
                end
                iat_pkg::MODE_STRING: begin
                    if (c == n_quote) begin
                        // column is that of the byte before the closing quote
                        recs[cnt] = mk_rec(iat_pkg::KIND_STRING, n_ts, n_off - n_ts,
                                           n_line, n_col, 12'd0);
                        cnt = cnt + 1'b1;
                        n_off = bump_off(n_off);
                        n_col = bump_sat(n_col);
                        n_mode = iat_pkg::MODE_BLANK;
                    end else begin
                        n_off = bump_off(n_off);
                        n_col = bump_sat(n_col);
                        if (iat_pkg::is_line_break(c)) begin
                            n_line = bump_sat(n_line);
                            n_col  = '0;
                        end
                    end
                end
                iat_pkg::MODE_COMMENT: begin
                    // CR is comment text, only LF closes the comment
                    if (c != iat_pkg::CH_LF) begin
                        n_off = bump_off(n_off);
                        n_col = bump_sat(n_col);
                    end else begin
                        to_blank = 1'b1;
                    end
                end
                default: begin
                    to_blank = 1'b1;
                end
            endcase

            if (to_blank) begin
                n_mode = iat_pkg::MODE_BLANK;
                if (c == iat_pkg::CH_SPACE) begin
                    n_indent = add_indent(n_indent, 4'd1);
                    n_off    = bump_off(n_off);
                    n_col    = bump_sat(n_col);
                end else if (c == iat_pkg::CH_TAB) begin
                    n_indent = add_indent(n_indent, r_tab_width);
                    n_off    = bump_off(n_off);
                    n_col    = bump_sat(n_col);
                end else if (iat_pkg::is_line_break(c)) begin
                    n_off    = bump_off(n_off);
                    n_line   = bump_sat(n_line);
                    n_col    = '0;
                    n_indent = '0;
                    n_als    = 1'b1;
                    n_ts     = n_off;
                end else if (c == iat_pkg::CH_HASH) begin
                    n_mode = iat_pkg::MODE_COMMENT;
                    n_off  = bump_off(n_off);
                    n_col  = bump_sat(n_col);
                end else begin
                    if ((n_indent != '0) && n_als) begin
                        recs[cnt] = mk_rec(iat_pkg::KIND_INDENT, n_ts, n_off - n_ts,
                                           n_line, n_col, n_indent);
                        cnt = cnt + 1'b1;
                    end
                    n_als    = 1'b0;
                    n_indent = '0;
                    n_ts     = n_off;
                    n_off    = bump_off(n_off);
                    n_col    = bump_sat(n_col);
                    if (iat_pkg::is_punct(c)) begin
                        recs[cnt] = mk_rec(iat_pkg::punct_kind(c), n_ts, n_off - n_ts,
                                           n_line, n_col, 12'd0);
                        cnt = cnt + 1'b1;
                    end else if (iat_pkg::is_op_start(c)) begin
                        n_held = c;
                        n_mode = iat_pkg::MODE_OP;
                    end else if ((c == iat_pkg::CH_DQUOTE) || (c == iat_pkg::CH_SQUOTE)) begin
                        n_quote = c;
                        n_ts    = n_off;
                        n_mode  = iat_pkg::MODE_STRING;
                    end else if (iat_pkg::is_digit(c)) begin
                        n_dot  = 1'b0;
                        n_mode = iat_pkg::MODE_NUMBER;
                    end else if (iat_pkg::is_alpha(c)) begin
                        n_mode = iat_pkg::MODE_IDENT;
                    end else begin
                        recs[cnt] = mk_rec(iat_pkg::KIND_UNKNOWN, n_ts, n_off - n_ts,
                                           n_line, n_col, 12'd0);
                        cnt = cnt + 1'b1;
                    end
                end
            end
            finish = i_byte.is_last;
        end

        if (finish) begin
            // flush the pending token, then EOF, then back to the start of a source
            case (n_mode)
                iat_pkg::MODE_IDENT: begin
                    recs[cnt] = mk_rec(iat_pkg::KIND_IDENT, n_ts, n_off - n_ts,
                                       n_line, n_col, 12'd0);
                    cnt = cnt + 1'b1;
                end
                iat_pkg::MODE_NUMBER: begin
                    recs[cnt] = mk_rec(n_dot ? iat_pkg::KIND_FLOAT : iat_pkg::KIND_INT,
                                       n_ts, n_off - n_ts, n_line, n_col, 12'd0);
                    cnt = cnt + 1'b1;
                end
                iat_pkg::MODE_OP: begin
                    recs[cnt] = mk_rec(iat_pkg::single_op_kind(n_held), n_ts,
                                       n_off - n_ts, n_line, n_col, 12'd0);
                    cnt = cnt + 1'b1;
                end
                iat_pkg::MODE_STRING: begin
                    recs[cnt] = mk_rec(iat_pkg::KIND_UNCLOSED, n_ts, n_off - n_ts,
                                       n_line, n_col, 12'd0);
                    cnt = cnt + 1'b1;
                end
                default: begin
                    if ((n_indent != '0) && n_als) begin
                        recs[cnt] = mk_rec(iat_pkg::KIND_INDENT, n_ts, n_off - n_ts,
                                           n_line, n_col, n_indent);
                        cnt = cnt + 1'b1;
                    end
                end
            endcase
            recs[cnt] = mk_rec(iat_pkg::KIND_EOF, n_off, 16'd0, n_line, n_col, 12'd0);
            cnt = cnt + 1'b1;

            n_mode   = iat_pkg::MODE_BLANK;
            n_held   = '0;
            n_quote  = '0;
            n_dot    = 1'b0;
            n_off    = '0;
            n_ts     = '0;
            n_line   = 16'd1;
            n_col    = '0;
            n_indent = '0;
            n_als    = 1'b1;
        end

        if (cnt != '0) begin
            recs[cnt - 1'b1].last_of_run = 1'b1;
        end
        bundle.count = cnt;
        bundle.recs  = recs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= iat_pkg::TAB_WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_tab_width <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= iat_pkg::MODE_BLANK;
            r_held   <= '0;
            r_quote  <= '0;
            r_dot    <= 1'b0;
            r_off    <= '0;
            r_ts     <= '0;
            r_line   <= 16'd1;
            r_col    <= '0;
            r_indent <= '0;
            r_als    <= 1'b1;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_quote  <= n_quote;
            r_dot    <= n_dot;
            r_off    <= n_off;
            r_ts     <= n_ts;
            r_line   <= n_line;
            r_col    <= n_col;
            r_indent <= n_indent;
            r_als    <= n_als;
        end
    end

endmodule

// ===== rtl/core/iat_queue.sv =====
`timescale 1ns / 1ps

module iat_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iat_pkg::t_qport  i_wr,
    output logic             o_full,
    output iat_pkg::t_qport  o_rd,
    input  logic             i_pop
);

    localparam int PTR_W = $clog2(iat_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(iat_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(iat_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(iat_pkg::QUEUE_DEPTH);

    iat_pkg::t_bundle r_mem [iat_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_full      = (r_count == FULL_CNT);
    assign push        = i_wr.valid && !o_full;
    assign pop         = i_pop && (r_count != '0);
    assign o_rd.valid  = (r_count != '0);
    assign o_rd.bundle = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/core/iat_back.sv =====
`timescale 1ns / 1ps

module iat_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iat_pkg::t_qport  i_rd,
    output logic             o_pop,
    iat_token_if.source      o_token
);

    logic [iat_pkg::COUNT_W-1:0] r_idx;
    logic                        r_ovalid;
    iat_pkg::t_token             r_out;
    logic                        load;
    logic                        last_rec;

    assign load     = i_rd.valid && (!r_ovalid || o_token.ready);
    assign last_rec = (r_idx == (i_rd.bundle.count - 1'b1));
    assign o_pop    = load && last_rec;

    assign o_token.valid         = r_ovalid;
    assign o_token.token_kind    = r_out.token_kind;
    assign o_token.start_offset  = r_out.start_offset;
    assign o_token.token_length  = r_out.token_length;
    assign o_token.line_number   = r_out.line_number;
    assign o_token.column_number = r_out.column_number;
    assign o_token.indent_amount = r_out.indent_amount;
    assign o_token.last_of_run   = r_out.last_of_run;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_rd.bundle.recs[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_idx    <= last_rec ? '0 : r_idx + 1'b1;
            end else if (o_token.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/indent_aware_tokenizer.sv =====
`timescale 1ns / 1ps
// Indent-aware tokenizer: source bytes in, token records out.
// i_byte  : one source byte per item (src_byte, is_last); a zero byte also ends the source.
// o_token : one token record per item; last_of_run marks the final token of a byte.
// i_cfg_wr_en / i_cfg_wr_data : write tab_width (indent columns per tab), reset value 4.
// The front classifies one byte per clock while the queue has room and pushes all
// tokens a byte causes (one to three; a byte with none pushes no entry) as one entry
// into a 4-entry queue; the back sends them from the queue head through an output register.
// Throughput: one byte per clock while the queue has room, one token per clock while ready.
// Ready drops only when the queue is full, e.g. when bytes cause tokens faster than
// the receiver takes them, or it stalls.
// The tokens of an accepted byte are written into the queue, and from its head into
// the output register that drives o_token. A stalled receiver holds the output record;
// bytes keep flowing until the queue fills.
// Reset (synchronous, active low) empties queue and output, returns the scanner to
// the start of a source (line 1, offset 0) and tab_width to 4. After the EOF token the
// scanner returns to the same start state on its own.
module indent_aware_tokenizer #(
    parameter longint unsigned SOURCE_BYTES = iat_pkg::SOURCE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    iat_byte_if.sink    i_byte,
    iat_token_if.source o_token
);

    iat_pkg::t_qport q_wr;
    iat_pkg::t_qport q_rd;
    logic            q_full;
    logic            q_pop;

    iat_front #(
        .SOURCE_BYTES (SOURCE_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (i_byte),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr)
    );

    iat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    iat_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (q_rd),
        .o_pop   (q_pop),
        .o_token (o_token)
    );

endmodule

// ===== rtl/core/iat_checker.sv =====
`timescale 1ns / 1ps

module iat_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    iat_token_if.source  i_token
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_token.valid)
        else $error("token output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_token.valid && !i_token.ready |=> i_token.valid
            && $stable(i_token.token_kind) && $stable(i_token.start_offset)
            && $stable(i_token.token_length) && $stable(i_token.last_of_run))
        else $error("stalled token record changed");

    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_token.valid && (i_token.token_kind == iat_pkg::KIND_EOF) |-> i_token.last_of_run)
        else $error("EOF token not marked last of run");

    a_indent_only_on_indent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_token.valid && (i_token.token_kind != iat_pkg::KIND_INDENT)
            |-> (i_token.indent_amount == 12'd0))
        else $error("indent amount on a non-indent token");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_token.valid |-> (i_token.line_number != 16'd0))
        else $error("line number zero");

endmodule

bind indent_aware_tokenizer iat_checker u_iat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_token (o_token)
);
